// ===== src/scss_pkg.sv =====
// Package: payload types and widths for the coordinate sort step block.
`timescale 1ns / 1ps
`default_nettype none
package scss_pkg;
   localparam int IDENT_W = 16;
   localparam int COORD_W = 32;
   localparam int POS_W   = 6;

   typedef struct packed {
      logic [IDENT_W-1:0]        ident;
      logic signed [COORD_W-1:0] coord;
      logic                      last_in;
   } req_type;

   typedef struct packed {
      logic [IDENT_W-1:0]        ident_out;
      logic signed [COORD_W-1:0] coord_out;
      logic [POS_W-1:0]          position;
      logic                      last_out;
      logic signed [COORD_W-1:0] step_out;
      logic                      step_valid;
      logic                      overflow;
   } rsp_type;
endpackage
`default_nettype wire

// ===== src/scss_div.sv =====
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module scss_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [33:0] dividend,
   input  wire logic [6:0]  divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic        run_ff, neg_ff, done_ff;
   logic [5:0]  cnt_ff;
   logic [33:0] q_ff;
   logic [6:0]  r_ff;
   logic [6:0]  d_ff;
   logic [7:0]  trial;
   logic [33:0] mag;
   logic signed [34:0] sq;

   assign mag   = dividend[33] ? (~dividend + 34'd1) : dividend;
   assign trial = {r_ff, q_ff[33]} - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'd33;
            q_ff   <= mag;
            r_ff   <= '0;
            d_ff   <= divisor;
            neg_ff <= dividend[33];
         end else if (run_ff) begin
            // shift in one dividend bit, subtract when it fits
            if (!trial[7]) begin
               r_ff <= trial[6:0];
               q_ff <= {q_ff[32:0], 1'b1};
            end else begin
               r_ff <= {r_ff[5:0], q_ff[33]};
               q_ff <= {q_ff[32:0], 1'b0};
            end
            if (cnt_ff == 6'd0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff - 6'd1;
         end
      end
   end

   // apply sign and saturate
   assign sq   = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
   assign done = done_ff;
   always_comb begin
      if (sq > 35'sd2147483647)       quotient = 32'h7FFF_FFFF;
      else if (sq < -35'sd2147483648) quotient = 32'h8000_0000;
      else                            quotient = sq[31:0];
   end
endmodule
`default_nettype wire

// ===== src/stable_coordinate_sort_step_top.sv =====
// Top level: collect pairs, insertion-sort by coordinate, emit sorted set with step.
// Operation: a non-last item is stored, or dropped and flagged when full. A last item
//   starts an insertion sort of the stored pairs (order read, coordinate read, compare),
//   then the ends are fetched, the step divider runs and each result is read and driven.
// Throughput: one set at a time; busy stays high from the last item until the
//   cycle of its final result. Results cannot be stalled by the receiver.
// Reset: synchronous, clears count, drop flag and sequencer; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module stable_coordinate_sort_step_top #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire scss_pkg::req_type req_item,
   output logic                   busy,
   output logic                   rsp_strobe,
   output scss_pkg::rsp_type      rsp_item
);
   import scss_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_OUTER, S_RD, S_CMP, S_PLACE, S_ENDS, S_DIV, S_WAITD, S_EMIT
   } state_type;

   // Memories: pairs in arrival order, and the sort permutation.
   logic [IDENT_W-1:0] ident_mem [MAX_ENTRIES];
   logic [COORD_W-1:0] coord_mem [MAX_ENTRIES];
   logic [AW-1:0]      order_mem [MAX_ENTRIES];

   state_type     state_ff;
   logic [CW-1:0] count_ff;
   logic          drop_ff;
   logic [AW-1:0] i_ff, j_ff;       // outer index, insertion slot
   logic [COORD_W-1:0] key_ff;
   logic [AW-1:0] prev_ff;          // order_mem[j-1] read back
   logic          rev_ff;
   logic [AW-1:0] first_ff;
   logic signed [COORD_W-1:0] c0_ff, cl_ff;
   logic [CW-1:0] o_ff;             // output counter
   logic [COORD_W-1:0] step_ff;
   logic          sv_ff;
   logic          strobe_ff;
   rsp_type       rsp_ff;

   // Registered read ports.
   logic [AW-1:0]      ord_addr;
   logic [AW-1:0]      ord_rd_ff;
   logic [AW-1:0]      crd_addr;
   logic [COORD_W-1:0] crd_rd_ff;
   logic [IDENT_W-1:0] idt_rd_ff;

   logic [CW-1:0] nm1;
   logic [AW-1:0] last_idx;
   logic          accept;
   logic          stored;
   logic          div_go, div_done;
   logic [31:0]   quo;
   logic [33:0]   diff;
   logic [AW-1:0] emit_slot;

   assign accept   = start && !busy;
   assign stored   = count_ff < CW'(MAX_ENTRIES);
   assign nm1      = count_ff - CW'(1);
   assign last_idx = nm1[AW-1:0];
   assign diff     = {{2{cl_ff[31]}}, cl_ff} - {{2{c0_ff[31]}}, c0_ff};
   assign emit_slot = rev_ff ? (last_idx - o_ff[AW-1:0]) : o_ff[AW-1:0];

   // Address steering for the permutation read port.
   always_comb begin
      case (state_ff)
         S_ENDS:  ord_addr = (i_ff == '0) ? '0 : last_idx;
         S_EMIT:  ord_addr = emit_slot;
         default: ord_addr = j_ff - AW'(1);
      endcase
   end

   // Coordinate read port: key fetch at the start of an insertion, otherwise
   // the entry named by the permutation read (compare, end capture or output).
   assign crd_addr = (state_ff == S_OUTER) ? i_ff : ord_rd_ff;

   always_ff @(posedge clock) begin
      ord_rd_ff <= order_mem[ord_addr];
      crd_rd_ff <= coord_mem[crd_addr];
      idt_rd_ff <= ident_mem[crd_addr];
      if (accept && stored) begin
         ident_mem[count_ff[AW-1:0]] <= req_item.ident;
         coord_mem[count_ff[AW-1:0]] <= req_item.coord;
      end
      if (state_ff == S_CMP && !($signed(crd_rd_ff) > $signed(key_ff)))
         order_mem[j_ff] <= i_ff;
      else if (state_ff == S_CMP)
         order_mem[j_ff] <= prev_ff;
      else if (state_ff == S_PLACE)
         order_mem[j_ff] <= i_ff;
   end

   assign div_go = (state_ff == S_DIV);

   scss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (diff),
      .divisor  (7'(nm1)),
      .done     (div_done),
      .quotient (quo)
   );

   // Sequencer. Insertion sort: for each i, walk j down from i comparing
   // coord[order[j-1]] against the key; S_RD fetches order[j-1], next cycle
   // its coordinate, S_CMP decides shift or place.
   logic [1:0] rd_phase_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         drop_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (stored) count_ff <= count_ff + CW'(1);
                  else        drop_ff  <= 1'b1;
                  if (req_item.last_in) begin
                     if (count_ff == '0 && !stored) begin
                        drop_ff <= 1'b0;
                     end else if (count_ff == '0 && stored) begin
                        state_ff <= S_OUTER;
                        i_ff     <= '0;
                     end else begin
                        state_ff <= S_OUTER;
                        i_ff     <= '0;
                     end
                  end
               end
            end
            S_OUTER: begin
               // key = coord of arrival i, read through the crd port this cycle
               j_ff        <= i_ff;
               rd_phase_ff <= 2'd0;
               state_ff    <= (i_ff == '0) ? S_PLACE : S_RD;
            end
            S_RD: begin
               // order read, then coordinate read
               rd_phase_ff <= rd_phase_ff + 2'd1;
               // first compare of an insertion: hold the key fetched in S_OUTER
               if (rd_phase_ff == 2'd0 && j_ff == i_ff) key_ff <= crd_rd_ff;
               if (rd_phase_ff == 2'd1) begin
                  prev_ff  <= ord_rd_ff;
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               if ($signed(crd_rd_ff) > $signed(key_ff)) begin
                  j_ff <= j_ff - AW'(1);
                  rd_phase_ff <= 2'd0;
                  state_ff <= (j_ff == AW'(1)) ? S_PLACE : S_RD;
               end else begin
                  state_ff <= S_ENDS;
                  rd_phase_ff <= 2'd3;
               end
            end
            S_PLACE: begin
               state_ff <= S_ENDS;
               rd_phase_ff <= 2'd3;
            end
            S_ENDS: begin
               // advance outer loop, or capture ends after last insertion
               if (rd_phase_ff == 2'd3) begin
                  if (CW'(i_ff) != nm1) begin
                     i_ff     <= i_ff + AW'(1);
                     state_ff <= S_OUTER;
                  end else begin
                     i_ff        <= '0;
                     rd_phase_ff <= 2'd0;
                  end
               end else begin
                  rd_phase_ff <= rd_phase_ff + 2'd1;
                  if (rd_phase_ff == 2'd0) begin
                     // second pass: crd_rd holds coord[order[0]]
                     if (i_ff != '0) c0_ff <= crd_rd_ff;
                  end else if (rd_phase_ff == 2'd1 && i_ff == '0) begin
                     first_ff    <= ord_rd_ff;
                     i_ff        <= AW'(1);
                     rd_phase_ff <= 2'd0;
                  end else if (rd_phase_ff == 2'd1) begin
                     rev_ff <= first_ff > ord_rd_ff;
                  end else begin
                     // rd_phase 2: crd_rd holds coord[order[n-1]]
                     if (first_ff > ord_rd_ff) begin
                        c0_ff <= crd_rd_ff;
                        cl_ff <= c0_ff;
                     end else begin
                        cl_ff <= crd_rd_ff;
                     end
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: state_ff <= S_WAITD;
            S_WAITD: begin
               if (div_done) begin
                  sv_ff       <= (count_ff > CW'(1)) && (diff != '0);
                  step_ff     <= quo;
                  o_ff        <= '0;
                  rd_phase_ff <= 2'd0;
                  state_ff    <= S_EMIT;
               end
            end
            S_EMIT: begin
               // order read, then entry read, then drive one result
               rd_phase_ff <= rd_phase_ff + 2'd1;
               if (rd_phase_ff == 2'd2) begin
                  rd_phase_ff        <= 2'd0;
                  strobe_ff          <= 1'b1;
                  rsp_ff.ident_out   <= idt_rd_ff;
                  rsp_ff.coord_out   <= crd_rd_ff;
                  rsp_ff.position    <= POS_W'(o_ff);
                  rsp_ff.last_out    <= (o_ff == nm1);
                  rsp_ff.step_valid  <= (o_ff == nm1) && sv_ff;
                  rsp_ff.step_out    <= ((o_ff == nm1) && sv_ff) ? step_ff : '0;
                  rsp_ff.overflow    <= drop_ff;
                  o_ff               <= o_ff + CW'(1);
                  if (o_ff == nm1) begin
                     count_ff <= '0;
                     drop_ff  <= 1'b0;
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.last_in && stored |=> busy)
      else $error("last item did not start sort");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count past capacity");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last_out |-> busy)
      else $error("result outside set");
endmodule
`default_nettype wire
